FILE: hdl/lehist_pkg.sv
// ----------------------------------------------------------------------------
// lehist_pkg
// Shared constants, types and helpers for the Laplacian edge histogram.
// ----------------------------------------------------------------------------
`default_nettype none

package lehist_pkg;

	localparam int MAX_ROW_BYTES = 512;
	localparam int COUNT_WIDTH   = 24;
	localparam int NUM_BINS      = 55;

	localparam int ADDR_W  = $clog2(MAX_ROW_BYTES);
	localparam int RBE_W   = $clog2(MAX_ROW_BYTES + 1);
	localparam int RB_W    = 10;
	localparam int LEVEL_W = 10;
	localparam int BIN_W   = 6;
	localparam int BIN_AW  = $clog2(NUM_BINS);
	localparam int LAP_W   = LEVEL_W + 3;
	localparam int SQ_W    = LEVEL_W + 2;
	localparam int ROOT_W  = (SQ_W + 1) / 2;
	localparam int OUT_W   = 24;
	localparam int PAL_AW  = 4;

	localparam logic [RB_W-1:0] ROW_BYTES_RESET = RB_W'(320);
	localparam logic [7:0] NIB_LO_MASK = 8'h0F;
	localparam logic [7:0] NIB_HI_MASK = 8'hF0;
	localparam int NIB_SHIFT = 4;

	localparam logic OP_PALETTE = 1'b0;
	localparam logic OP_PIXEL   = 1'b1;

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	typedef struct packed {
		logic [ADDR_W-1:0] rd_a_addr;
		logic [ADDR_W-1:0] rd_b_addr;
		logic              above_we;
		logic [ADDR_W-1:0] above_waddr;
		logic [7:0]        above_wdata;
		logic              mid_we;
		logic [ADDR_W-1:0] mid_waddr;
		logic [7:0]        mid_wdata;
	} line_req_t;

	typedef struct packed {
		logic [7:0] up;
		logic [7:0] mid_a;
		logic [7:0] mid_b;
	} line_rsp_t;

	function automatic logic [PAL_AW-1:0] nib_hi(input logic [7:0] b);
		return PAL_AW'((b & NIB_HI_MASK) >> NIB_SHIFT);
	endfunction

	function automatic logic [PAL_AW-1:0] nib_lo(input logic [7:0] b);
		return PAL_AW'(b & NIB_LO_MASK);
	endfunction

	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
		return (v == COUNT_MAX) ? COUNT_MAX : v + COUNT_WIDTH'(1);
	endfunction

endpackage

`default_nettype wire

FILE: hdl/lehist_pal.sv
// ----------------------------------------------------------------------------
// lehist_pal
// Palette memory: 16 intensity levels, one write port, two registered reads.
// ----------------------------------------------------------------------------
`default_nettype none

module lehist_pal import lehist_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               we,
	input  wire logic [PAL_AW-1:0]  waddr,
	input  wire logic [LEVEL_W-1:0] wdata,
	input  wire logic [PAL_AW-1:0]  raddr_a,
	input  wire logic [PAL_AW-1:0]  raddr_b,
	output logic      [LEVEL_W-1:0] level_a,
	output logic      [LEVEL_W-1:0] level_b
);

	logic [LEVEL_W-1:0] mem [2**PAL_AW];
	logic [2**PAL_AW-1:0] valid_q;
	logic [LEVEL_W-1:0] dout_a_q, dout_b_q;
	logic va_q, vb_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		dout_a_q <= mem[raddr_a];
		dout_b_q <= mem[raddr_b];
	end

	// unwritten entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			va_q    <= 1'b0;
			vb_q    <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			va_q <= valid_q[raddr_a];
			vb_q <= valid_q[raddr_b];
		end
	end

	assign level_a = va_q ? dout_a_q : '0;
	assign level_b = vb_q ? dout_b_q : '0;

endmodule

`default_nettype wire

FILE: hdl/lehist_lines.sv
// ----------------------------------------------------------------------------
// lehist_lines
// Two line stores: the row above (one read port) and the middle row (two).
// ----------------------------------------------------------------------------
`default_nettype none

module lehist_lines import lehist_pkg::*; (
	input  wire logic      clk,
	input  wire line_req_t req,
	output line_rsp_t      rsp
);

	logic [7:0] above_mem [MAX_ROW_BYTES];
	logic [7:0] mid_mem [MAX_ROW_BYTES];

	always_ff @(posedge clk) begin
		if (req.above_we) begin
			above_mem[req.above_waddr] <= req.above_wdata;
		end
		if (req.mid_we) begin
			mid_mem[req.mid_waddr] <= req.mid_wdata;
		end
		rsp.up    <= above_mem[req.rd_a_addr];
		rsp.mid_a <= mid_mem[req.rd_a_addr];
		rsp.mid_b <= mid_mem[req.rd_b_addr];
	end

endmodule

`default_nettype wire

FILE: hdl/lehist_bins.sv
// ----------------------------------------------------------------------------
// lehist_bins
// Histogram memory: one count per bin, valid bits give the cleared state.
// ----------------------------------------------------------------------------
`default_nettype none

module lehist_bins import lehist_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic [BIN_AW-1:0]      addr,
	input  wire logic                   we,
	input  wire logic [COUNT_WIDTH-1:0] wdata,
	input  wire logic                   clear_all,
	output logic      [COUNT_WIDTH-1:0] rdata
);

	logic [COUNT_WIDTH-1:0] mem [NUM_BINS];
	logic [NUM_BINS-1:0] valid_q;
	logic [COUNT_WIDTH-1:0] dout_q;
	logic v_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		dout_q <= mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			v_q     <= 1'b0;
		end else begin
			if (clear_all) begin
				valid_q <= '0;
			end else if (we) begin
				valid_q[addr] <= 1'b1;
			end
			v_q <= valid_q[addr];
		end
	end

	assign rdata = v_q ? dout_q : '0;

endmodule

`default_nettype wire

FILE: hdl/lehist_sqrt.sv
// ----------------------------------------------------------------------------
// lehist_sqrt
// Integer square root, one result bit per cycle, most significant first.
// ----------------------------------------------------------------------------
`default_nettype none

module lehist_sqrt import lehist_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [SQ_W-1:0]   value,
	output logic                   done,
	output logic      [ROOT_W-1:0] root
);

	localparam int IDX_W = $clog2(ROOT_W + 1);

	logic busy_q;
	logic [IDX_W-1:0] idx_q;
	logic [SQ_W-1:0] value_q;
	logic [ROOT_W-1:0] root_q;
	logic [ROOT_W-1:0] trial;
	logic [2*ROOT_W-1:0] square;
	logic keep;

	assign trial  = root_q | (ROOT_W'(1) << idx_q);
	assign square = (2*ROOT_W)'(trial) * (2*ROOT_W)'(trial);
	assign keep   = (32'(square) <= 32'(value_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			idx_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				idx_q  <= IDX_W'(ROOT_W - 1);
			end else if (busy_q) begin
				if (idx_q == '0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end else begin
					idx_q <= idx_q - IDX_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			value_q <= value;
			root_q  <= '0;
		end else if (busy_q && keep) begin
			root_q <= trial;
		end
	end

	assign root = root_q;

endmodule

`default_nettype wire

FILE: hdl/laplacian_edge_histogram.sv
// ----------------------------------------------------------------------------
// laplacian_edge_histogram
// Histogram of 4-neighbour Laplacian edge strength over a palettized image.
// ----------------------------------------------------------------------------
// Input channel s_*: tuser[0] = opcode. Opcode 0 writes palette entry
// palette_index with palette_level. Opcode 1 delivers a byte of two pixels,
// high nibble left; tlast marks the final byte of the frame. Row length comes
// from row_bytes_wdata; the user writes it only while the block is idle, and
// the block does not enforce this. A pixel byte passes through the line store
// reads and palette reads, then, per positive response of an interior byte,
// through the bit-serial square root and the histogram read-modify-write.
// On the frame-end byte the 55 bins go out on m_*, bin 55 first, bin 1 with
// tlast; each bin takes a memory read and a load.
// m_tvalid holds its item while m_tready is low; read-out waits for it.
// s_tready is high only while the sequencer is idle.
// Reset clears palette and histogram valid bits, counters and row position;
// the line stores are not cleared. row_bytes resets to 320.
// ----------------------------------------------------------------------------
`default_nettype none

module laplacian_edge_histogram import lehist_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        row_bytes_we,
	input  wire logic [9:0]  row_bytes_wdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,  // palette_index, palette_level, pixel_pair
	input  wire logic [0:0]  s_tuser,  // opcode
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [55:0] m_tdata,  // bin, count, total
	output logic             m_tlast
);

	typedef enum logic [14:0] {
		ST_IDLE  = 15'b000000000000001,
		ST_RD1   = 15'b000000000000010,
		ST_RD2   = 15'b000000000000100,
		ST_PAL1  = 15'b000000000001000,
		ST_PAL2  = 15'b000000000010000,
		ST_PAL3  = 15'b000000000100000,
		ST_PAL4  = 15'b000000001000000,
		ST_LAP   = 15'b000000010000000,
		ST_TCHK  = 15'b000000100000000,
		ST_SQ    = 15'b000001000000000,
		ST_BRD   = 15'b000010000000000,
		ST_BWR   = 15'b000100000000000,
		ST_FIN   = 15'b001000000000000,
		ST_RO_RD = 15'b010000000000000,
		ST_RO_LD = 15'b100000000000000
	} state_t;

	state_t state_q;

	logic [RB_W-1:0] row_bytes_q;
	logic [ADDR_W-1:0] col_q, c_q;
	logic [1:0] rows_q;
	logic [7:0] held_q, x_q;
	logic fe_q, interior_q, row_end_q, sel_q;
	logic [7:0] up_q, mid_c_q, mid_r_q, mid_l_q;
	logic [LEVEL_W-1:0] cl_q, cr_q, uh_q, ul_q, xh_q, xl_q, ll_q, rh_q;
	logic signed [LAP_W-1:0] lap0_q, lap1_q, lap_sel;
	logic [BIN_W-1:0] bin_q, ro_bin_q;
	logic [COUNT_WIDTH-1:0] total_q;
	logic [BIN_W-1:0] out_bin_q;
	logic [OUT_W-1:0] out_count_q, out_total_q;
	logic out_valid_q, out_last_q;

	// input fields
	logic               in_opcode;
	logic [PAL_AW-1:0]  in_pal_index;
	logic [LEVEL_W-1:0] in_pal_level;
	logic [7:0]         in_pixel_pair;
	logic               in_accept, pix_accept;

	assign in_opcode     = s_tuser[0];
	assign in_pal_index  = s_tdata[3:0];
	assign in_pal_level  = s_tdata[13:4];
	assign in_pixel_pair = s_tdata[21:14];
	assign s_tready      = (state_q == ST_IDLE);
	assign in_accept     = s_tvalid && s_tready;
	assign pix_accept    = in_accept && (in_opcode == OP_PIXEL);

	// effective row length and position flags
	logic [RBE_W-1:0] rb_eff;
	logic interior_d, row_end_d;

	always_comb begin
		if (row_bytes_q == '0) begin
			rb_eff = RBE_W'(1);
		end else if (32'(row_bytes_q) > MAX_ROW_BYTES) begin
			rb_eff = RBE_W'(MAX_ROW_BYTES);
		end else begin
			rb_eff = RBE_W'(row_bytes_q);
		end
		interior_d = (rows_q == 2'd2) && (col_q != '0) && (32'(col_q) + 2 <= 32'(rb_eff));
		row_end_d  = (32'(col_q) + 1 >= 32'(rb_eff));
	end

	// line stores
	line_req_t line_req;
	line_rsp_t line_rsp;

	always_comb begin
		line_req             = '0;
		line_req.rd_a_addr   = (state_q == ST_IDLE) ? col_q : c_q - ADDR_W'(1);
		line_req.rd_b_addr   = col_q + ADDR_W'(1);
		line_req.above_waddr = c_q - ADDR_W'(1);
		line_req.above_wdata = line_rsp.mid_a;
		line_req.mid_waddr   = c_q - ADDR_W'(1);
		line_req.mid_wdata   = held_q;
		if (state_q == ST_RD2) begin
			line_req.above_we = (c_q != '0);
			line_req.mid_we   = (c_q != '0);
		end else if (state_q == ST_PAL1) begin
			line_req.above_we    = row_end_q;
			line_req.above_waddr = c_q;
			line_req.above_wdata = mid_c_q;
			line_req.mid_we      = row_end_q;
			line_req.mid_waddr   = c_q;
			line_req.mid_wdata   = x_q;
		end
	end

	lehist_lines u_lines (
		.clk (clk),
		.req (line_req),
		.rsp (line_rsp)
	);

	// palette
	logic [PAL_AW-1:0] pal_ra, pal_rb;
	logic [LEVEL_W-1:0] pal_a, pal_b;

	always_comb begin
		pal_ra = nib_hi(mid_c_q);
		pal_rb = nib_lo(mid_c_q);
		if (state_q == ST_PAL1) begin
			pal_ra = nib_hi(up_q);
			pal_rb = nib_lo(up_q);
		end else if (state_q == ST_PAL2) begin
			pal_ra = nib_hi(x_q);
			pal_rb = nib_lo(x_q);
		end else if (state_q == ST_PAL3) begin
			pal_ra = nib_lo(mid_l_q);
			pal_rb = nib_hi(mid_r_q);
		end
	end

	lehist_pal u_pal (
		.clk     (clk),
		.arst_n  (arst_n),
		.we      (in_accept && (in_opcode == OP_PALETTE)),
		.waddr   (in_pal_index),
		.wdata   (in_pal_level),
		.raddr_a (pal_ra),
		.raddr_b (pal_rb),
		.level_a (pal_a),
		.level_b (pal_b)
	);

	// square root of the selected response
	logic lap_pos, sq_start, sq_done;
	logic [ROOT_W-1:0] sq_root;
	logic [BIN_W-1:0] root_clamped;

	assign lap_sel  = sel_q ? lap1_q : lap0_q;
	assign lap_pos  = !lap_sel[LAP_W-1] && (lap_sel != '0);
	assign sq_start = (state_q == ST_TCHK) && interior_q && lap_pos;

	lehist_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.value  (lap_sel[SQ_W-1:0]),
		.done   (sq_done),
		.root   (sq_root)
	);

	assign root_clamped = (32'(sq_root) > NUM_BINS) ? BIN_W'(NUM_BINS) : BIN_W'(sq_root);

	// histogram
	logic [BIN_AW-1:0] bin_addr;
	logic [COUNT_WIDTH-1:0] bin_rdata;
	logic ro_load, ro_final;

	assign bin_addr = (state_q == ST_RO_RD || state_q == ST_RO_LD) ?
		BIN_AW'(ro_bin_q - BIN_W'(1)) : BIN_AW'(bin_q - BIN_W'(1));
	assign ro_load  = (state_q == ST_RO_LD) && (!out_valid_q || m_tready);
	assign ro_final = ro_load && (ro_bin_q == BIN_W'(1));

	lehist_bins u_bins (
		.clk       (clk),
		.arst_n    (arst_n),
		.addr      (bin_addr),
		.we        (state_q == ST_BWR),
		.wdata     (sat_inc(bin_rdata)),
		.clear_all (ro_final),
		.rdata     (bin_rdata)
	);

	// level sums for the two pixels of the middle byte
	logic [LEVEL_W+1:0] sum0, sum1;
	assign sum0 = (LEVEL_W+2)'(uh_q) + (LEVEL_W+2)'(xh_q) + (LEVEL_W+2)'(ll_q)
		+ (LEVEL_W+2)'(cr_q);
	assign sum1 = (LEVEL_W+2)'(ul_q) + (LEVEL_W+2)'(xl_q) + (LEVEL_W+2)'(cl_q)
		+ (LEVEL_W+2)'(rh_q);

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_bytes_q <= ROW_BYTES_RESET;
			col_q       <= '0;
			rows_q      <= '0;
			held_q      <= '0;
			total_q     <= '0;
			sel_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (row_bytes_we) begin
				row_bytes_q <= row_bytes_wdata;
			end
			if (out_valid_q && m_tready && !ro_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pix_accept) begin
						col_q <= row_end_d ? '0 : col_q + ADDR_W'(1);
						if (row_end_d && rows_q != 2'd2) begin
							rows_q <= rows_q + 2'd1;
						end
						state_q <= ST_RD1;
					end
				end
				ST_RD1: state_q <= ST_RD2;
				ST_RD2: begin
					held_q  <= x_q;
					state_q <= ST_PAL1;
				end
				ST_PAL1: state_q <= ST_PAL2;
				ST_PAL2: state_q <= ST_PAL3;
				ST_PAL3: state_q <= ST_PAL4;
				ST_PAL4: state_q <= ST_LAP;
				ST_LAP: begin
					sel_q   <= 1'b0;
					state_q <= ST_TCHK;
				end
				ST_TCHK: begin
					if (sq_start) begin
						state_q <= ST_SQ;
					end else if (!sel_q) begin
						sel_q <= 1'b1;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_SQ: begin
					if (sq_done) begin
						state_q <= ST_BRD;
					end
				end
				ST_BRD: state_q <= ST_BWR;
				ST_BWR: begin
					total_q <= sat_inc(total_q);
					if (!sel_q) begin
						sel_q   <= 1'b1;
						state_q <= ST_TCHK;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fe_q) begin
						col_q   <= '0;
						rows_q  <= '0;
						held_q  <= '0;
						state_q <= ST_RO_RD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_RO_RD: state_q <= ST_RO_LD;
				ST_RO_LD: begin
					if (ro_load) begin
						out_valid_q <= 1'b1;
						if (ro_final) begin
							total_q <= '0;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_RO_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (pix_accept) begin
			c_q        <= col_q;
			x_q        <= in_pixel_pair;
			fe_q       <= s_tlast;
			interior_q <= interior_d;
			row_end_q  <= row_end_d;
		end
		if (state_q == ST_RD1) begin
			up_q    <= line_rsp.up;
			mid_c_q <= line_rsp.mid_a;
			mid_r_q <= line_rsp.mid_b;
		end
		if (state_q == ST_RD2) begin
			mid_l_q <= line_rsp.mid_a;
		end
		if (state_q == ST_PAL1) begin
			cl_q <= pal_a;
			cr_q <= pal_b;
		end
		if (state_q == ST_PAL2) begin
			uh_q <= pal_a;
			ul_q <= pal_b;
		end
		if (state_q == ST_PAL3) begin
			xh_q <= pal_a;
			xl_q <= pal_b;
		end
		if (state_q == ST_PAL4) begin
			ll_q <= pal_a;
			rh_q <= pal_b;
		end
		if (state_q == ST_LAP) begin
			lap0_q <= $signed({1'b0, cl_q, 2'b00}) - $signed({1'b0, sum0});
			lap1_q <= $signed({1'b0, cr_q, 2'b00}) - $signed({1'b0, sum1});
		end
		if (state_q == ST_SQ && sq_done) begin
			bin_q <= root_clamped;
		end
		if (state_q == ST_FIN) begin
			ro_bin_q <= BIN_W'(NUM_BINS);
		end else if (ro_load) begin
			ro_bin_q <= ro_bin_q - BIN_W'(1);
		end
		if (ro_load) begin
			out_bin_q   <= ro_bin_q;
			out_count_q <= OUT_W'(bin_rdata);
			out_total_q <= OUT_W'(total_q);
			out_last_q  <= ro_final;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_total_q, out_count_q, out_bin_q};
	assign m_tlast  = out_last_q;

`ifndef SYNTH
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	a_pixel_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pix_accept |=> !s_tready)
		else $error("pixel item accepted while previous still in work");

	a_last_bin_one: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (m_tdata[5:0] == 6'd1))
		else $error("last flag on a bin other than one");

	a_bin_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BWR) |-> (bin_q != '0 && 32'(bin_q) <= NUM_BINS))
		else $error("histogram update outside the bin range");
`endif

endmodule

`default_nettype wire

FILE: dv/tb_laplacian_edge_histogram.sv
// ----------------------------------------------------------------------------
// tb_laplacian_edge_histogram
// Self-checking bench for the Laplacian edge histogram: palette loads and
// pixel frames go in over s_*, every bin read-out is predicted and compared.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_laplacian_edge_histogram import lehist_pkg::*; ();

	logic        clk;
	logic        arst_n;
	logic        row_bytes_we;
	logic [9:0]  row_bytes_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // palette_index, palette_level, pixel_pair
	logic [0:0]  s_tuser;   // opcode
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;   // bin, count, total
	logic        m_tlast;

	laplacian_edge_histogram i_dut (
		.clk(clk), .arst_n(arst_n),
		.row_bytes_we(row_bytes_we), .row_bytes_wdata(row_bytes_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	typedef struct packed {
		logic [5:0]  bin;
		logic [23:0] count;
		logic [23:0] total;
		logic        last;
	} bin_item_t;

	// predictor state
	logic [9:0]             row_len;
	logic [LEVEL_W-1:0]     pal[16];
	logic [7:0]             line_up[MAX_ROW_BYTES];
	logic [7:0]             line_mid[MAX_ROW_BYTES];
	logic [7:0]             held;
	int unsigned            col;
	int unsigned            rows;
	logic [COUNT_WIDTH-1:0] hist[NUM_BINS];
	logic [COUNT_WIDTH-1:0] pos_total;

	bin_item_t   expected_bins[$];
	int          errors;
	int          frames;
	int          items_sent;
	bit          quiet;       // no idling on either side
	int unsigned cur_len;     // row length the stimulus uses

	initial begin
		clk = 1'b0;
	end
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [23:0] sat_up(input logic [23:0] v);
		return (v == 24'hFFFFFF) ? v : v + 24'd1;
	endfunction

	function automatic void count_response(input int lap);
		int r;
		if (lap <= 0)
			return;
		r = 0;
		while ((r + 1) * (r + 1) <= lap)
			r++;
		if (r > NUM_BINS)
			r = NUM_BINS;
		hist[r-1] = sat_up(hist[r-1]);
		pos_total = sat_up(pos_total);
	endfunction

	function automatic int lv_hi(input logic [7:0] b);
		return int'(pal[b[7:4]]);
	endfunction

	function automatic int lv_lo(input logic [7:0] b);
		return int'(pal[b[3:0]]);
	endfunction

	function automatic void predict_item(input logic op, input logic [3:0] idx,
			input logic [9:0] lvl, input logic [7:0] x, input logic fe);
		int unsigned rb, c;
		logic [7:0] up, mid, lft, rgt;
		bin_item_t e;
		if (op == OP_PALETTE) begin
			pal[idx] = lvl;
			return;
		end
		rb = (row_len == 0) ? 1 : (row_len > MAX_ROW_BYTES) ? MAX_ROW_BYTES : row_len;
		c = (col >= MAX_ROW_BYTES) ? MAX_ROW_BYTES - 1 : col;
		if (rows >= 2 && c >= 1 && c + 2 <= rb) begin
			up = line_up[c]; mid = line_mid[c];
			lft = line_mid[c-1]; rgt = line_mid[c+1];
			count_response(4 * lv_hi(mid) - (lv_hi(up) + lv_hi(x) + lv_lo(lft) + lv_lo(mid)));
			count_response(4 * lv_lo(mid) - (lv_lo(up) + lv_lo(x) + lv_hi(mid) + lv_hi(rgt)));
		end
		if (c >= 1) begin
			line_up[c-1] = line_mid[c-1];
			line_mid[c-1] = held;
		end
		held = x;
		if (c + 1 >= rb) begin
			line_up[c] = line_mid[c];
			line_mid[c] = x;
			col = 0;
			if (rows < 2)
				rows++;
		end else
			col = c + 1;
		if (!fe)
			return;
		for (int b = NUM_BINS; b >= 1; b--) begin
			e.bin = 6'(b);
			e.count = hist[b-1];
			e.total = pos_total;
			e.last = (b == 1);
			expected_bins.push_back(e);
		end
		for (int b = 0; b < NUM_BINS; b++)
			hist[b] = '0;
		pos_total = '0;
		col = 0;
		rows = 0;
		held = '0;
	endfunction

	// tvalid stays high after an accept; the next item or an idle gap takes it over
	task automatic send_item(input logic op, input logic [3:0] idx, input logic [9:0] lvl,
			input logic [7:0] x, input logic fe);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {2'b00, x, lvl, idx};
		s_tlast  <= fe;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_item(op, idx, lvl, x, fe);
		items_sent++;
	endtask

	task automatic load_palette(input logic [3:0] idx, input logic [9:0] lvl);
		send_item(OP_PALETTE, idx, lvl, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_bins.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_row_bytes(input logic [9:0] v);
		wait_drained();
		row_bytes_we <= 1'b1;
		row_bytes_wdata <= v;
		@(posedge clk);
		row_bytes_we <= 1'b0;
		row_len = v;
		cur_len = (v == 0) ? 1 : (v > MAX_ROW_BYTES) ? MAX_ROW_BYTES : v;
	endtask

	// frame of n rows; mode 0 random bytes, 1 all same, 2 checker of two indices
	task automatic send_frame(input int nrows, input int mode);
		logic [7:0] b;
		int total;
		total = nrows * cur_len;
		for (int i = 0; i < total; i++) begin
			case (mode)
				1: b = 8'h00;
				2: b = ((i / cur_len) % 2 == (i % 2)) ? 8'hF0 : 8'h0F;
				default: b = 8'($urandom_range(0, 255));
			endcase
			send_item(OP_PIXEL, 4'($urandom_range(0, 15)), 10'($urandom_range(0, 1023)), b,
				i == total - 1);
		end
	endtask

	task automatic test_directed();
		// extremes of level: entry 15 full scale, including values above 765
		load_palette(4'hF, 10'd1023);
		load_palette(4'h0, 10'd0);
		load_palette(4'h1, 10'd765);
		set_row_bytes(10'd3);
		send_frame(3, 2);     // bright/dark checker, responses past bin 55
		send_frame(3, 1);     // flat image, nothing counted
		// frame end on a single byte before any row is complete
		send_item(OP_PIXEL, 4'h0, 10'd0, 8'hFF, 1'b1);
		wait_drained();
	endtask

	task automatic test_short_rows();
		// rows too short for interior pixels
		set_row_bytes(10'd0);
		send_frame(3, 0);
		set_row_bytes(10'd2);
		send_frame(3, 0);
	endtask

	task automatic test_random_frames();
		int n;
		for (int p = 0; p < 16; p++)
			load_palette(4'(p), 10'($urandom_range(0, 1023)));
		n = 0;
		while (items_sent < 400) begin
			set_row_bytes(10'($urandom_range(3, 8)));
			if ($urandom_range(0, 3) == 0)
				load_palette(4'($urandom_range(0, 15)), 10'($urandom_range(0, 1023)));
			send_frame($urandom_range(3, 6), 0);
			n++;
		end
	endtask

	task automatic test_wide_rows();
		// row length above the maximum: a partial row, no row end inside it
		set_row_bytes(10'd1023);
		for (int i = 0; i < 40; i++)
			send_item(OP_PIXEL, 4'($urandom_range(0, 15)), 10'($urandom_range(0, 1023)),
				8'($urandom_range(0, 255)), i == 39);
	endtask

	// result checker
	always @(posedge clk) begin
		bin_item_t got, want;
		if (m_tvalid && m_tready && arst_n) begin
			got = {m_tdata[5:0], m_tdata[29:6], m_tdata[53:30], m_tlast};
			if (expected_bins.size() == 0) begin
				$display("%0t: unexpected bin item %h", $realtime, got);
				errors++;
			end else begin
				want = expected_bins.pop_front();
				if (got !== want) begin
					$display("%0t: bin mismatch expected bin %0d count %0d total %0d last %b,",
						$realtime, want.bin, want.count, want.total, want.last);
					$display("%0t:   got bin %0d count %0d total %0d last %b",
						$realtime, got.bin, got.count, got.total, got.last);
					errors++;
				end
				if (want.last)
					frames++;
			end
		end
	end

	// receiver stalls
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	initial begin
		arst_n = 1'b0;
		row_bytes_we = 1'b0;
		row_bytes_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		s_tlast = 1'b0;
		errors = 0; frames = 0; items_sent = 0; quiet = 0;
		row_len = ROW_BYTES_RESET;
		cur_len = 320;
		held = '0; col = 0; rows = 0; pos_total = '0;
		for (int i = 0; i < 16; i++)
			pal[i] = '0;
		for (int i = 0; i < NUM_BINS; i++)
			hist[i] = '0;
		for (int i = 0; i < MAX_ROW_BYTES; i++) begin
			line_up[i] = '0;
			line_mid[i] = '0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_short_rows();
		test_random_frames();
		test_wide_rows();
		quiet = 1;
		set_row_bytes(10'd5);
		send_frame(4, 0);
		wait_drained();
		$display("Covered %0d input items and %0d histogram read-outs over row lengths 0..1023,",
			items_sent, frames);
		$display("with palette extremes, flat and saturating images, and random stalls.");
		if (errors == 0)
			$display("tb_laplacian_edge_histogram OK");
		else
			$display("tb_laplacian_edge_histogram NOT OK");
		$finish;
	end

	initial begin
		#30ms;
		$display("tb_laplacian_edge_histogram NOT OK");
		$finish;
	end

endmodule

`default_nettype wire
